FILE: rtl/core/ssop_pkg.sv
// ssop_pkg: shared types and codes for the sorted set operations block.
// Used by every module under rtl/core; depends on nothing.
package ssop_pkg;

    localparam int VALUE_W     = 32;
    localparam int OUT_COUNT_W = 6;
    localparam int REQ_W       = 2;
    localparam int MODE_W      = 2;
    localparam int KIND_W      = 2;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_APPEND_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN      = 2'd2;

    // op_mode register codes
    localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTER  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUBSET = 2'd2;

    // internal command kinds queued between front and back
    localparam logic [KIND_W-1:0] CMD_APPEND_A = 2'd0;
    localparam logic [KIND_W-1:0] CMD_APPEND_B = 2'd1;
    localparam logic [KIND_W-1:0] CMD_RUN      = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      is_element;
        logic                      subset;
        logic [OUT_COUNT_W-1:0]    out_count;
        logic                      overflow;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

endpackage

FILE: rtl/core/ssop_front.sv
// ssop_front: accepts input items, classifies them into queue commands.
// Depends on ssop_pkg.
module ssop_front (
    input  logic              i_in_valid,
    input  ssop_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output ssop_pkg::t_cmd    o_push_cmd
);

    logic known;

    always_comb begin
        known            = 1'b1;
        o_push_cmd.value = i_in_item.value;
        case (i_in_item.req_type)
            ssop_pkg::REQ_APPEND_A: o_push_cmd.kind = ssop_pkg::CMD_APPEND_A;
            ssop_pkg::REQ_APPEND_B: o_push_cmd.kind = ssop_pkg::CMD_APPEND_B;
            ssop_pkg::REQ_RUN: begin
                o_push_cmd.kind  = ssop_pkg::CMD_RUN;
                o_push_cmd.value = '0;
            end
            default: begin
                // unknown request: taken and dropped
                o_push_cmd.kind = ssop_pkg::CMD_RUN;
                known           = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && known;

endmodule

FILE: rtl/core/ssop_cmdq.sv
// ssop_cmdq: two-entry command queue between front and back.
// Depends on ssop_pkg.
module ssop_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssop_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    output logic           o_valid,
    output ssop_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    ssop_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/core/ssop_back.sv
// ssop_back: list storage and the run sequencer (merge, intersect, subset).
// Depends on ssop_pkg; fed by ssop_cmdq, drives the output register.
module ssop_back #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ssop_pkg::MODE_W-1:0]   i_mode,
    input  logic                          i_cmd_valid,
    input  ssop_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_out_valid,
    output ssop_pkg::t_out_item           o_out_item,
    input  logic                          i_out_stall
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MERGE = 3'd1;
    localparam logic [2:0] ST_INTER = 3'd2;
    localparam logic [2:0] ST_SUB   = 3'd3;
    localparam logic [2:0] ST_TERM  = 3'd4;

    logic signed [ssop_pkg::VALUE_W-1:0] r_list_a [LIST_DEPTH];
    logic signed [ssop_pkg::VALUE_W-1:0] r_list_b [LIST_DEPTH];

    logic [2:0]                        r_state, n_state;
    logic [CW-1:0]                     r_count_a, n_count_a;
    logic [CW-1:0]                     r_count_b, n_count_b;
    logic [CW-1:0]                     r_i, n_i;
    logic [CW-1:0]                     r_j, n_j;
    logic [ssop_pkg::OUT_COUNT_W-1:0]  r_k, n_k;
    logic                              r_dropped, n_dropped;
    logic                              r_sub, n_sub;
    logic                              r_out_valid;
    ssop_pkg::t_out_item               r_out_item;

    logic                              we_a, we_b;
    logic                              out_free;
    logic                              a_ok, b_ok;
    logic signed [ssop_pkg::VALUE_W-1:0] a_val, b_val;
    logic                              emit;
    ssop_pkg::t_out_item               emit_item;

    assign out_free = !r_out_valid || !i_out_stall;
    assign a_ok     = (r_i < r_count_a);
    assign b_ok     = (r_j < r_count_b);
    assign a_val    = r_list_a[r_i[IW-1:0]];
    assign b_val    = r_list_b[r_j[IW-1:0]];

    always_comb begin
        n_state   = r_state;
        n_count_a = r_count_a;
        n_count_b = r_count_b;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_dropped = r_dropped;
        n_sub     = r_sub;
        o_cmd_pop = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        emit      = 1'b0;
        emit_item            = '0;
        emit_item.is_element = 1'b1;
        emit_item.overflow   = r_dropped;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        ssop_pkg::CMD_APPEND_A: begin
                            if (r_count_a < DEPTH_C) begin
                                we_a      = 1'b1;
                                n_count_a = r_count_a + 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        ssop_pkg::CMD_APPEND_B: begin
                            if (r_count_b < DEPTH_C) begin
                                we_b      = 1'b1;
                                n_count_b = r_count_b + 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        ssop_pkg::CMD_RUN: begin
                            n_i   = '0;
                            n_j   = '0;
                            n_k   = '0;
                            n_sub = 1'b0;
                            case (i_mode)
                                ssop_pkg::MODE_MERGE:  n_state = ST_MERGE;
                                ssop_pkg::MODE_INTER:  n_state = ST_INTER;
                                ssop_pkg::MODE_SUBSET: n_state = ST_SUB;
                                default:               n_state = ST_TERM;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end

            ST_MERGE: begin
                if (out_free) begin
                    if (a_ok && (!b_ok || (a_val < b_val))) begin
                        emit                = 1'b1;
                        emit_item.value_res = a_val;
                        n_i                 = r_i + 1'b1;
                    end else if (b_ok) begin
                        // tie goes to B
                        emit                = 1'b1;
                        emit_item.value_res = b_val;
                        n_j                 = r_j + 1'b1;
                    end else begin
                        n_state = ST_TERM;
                    end
                end
            end

            ST_INTER: begin
                if (out_free) begin
                    if (a_ok && b_ok) begin
                        if (a_val < b_val) begin
                            n_i = r_i + 1'b1;
                        end else if (b_val < a_val) begin
                            n_j = r_j + 1'b1;
                        end else begin
                            emit                = 1'b1;
                            emit_item.value_res = a_val;
                            n_i                 = r_i + 1'b1;
                            n_j                 = r_j + 1'b1;
                        end
                    end else begin
                        n_state = ST_TERM;
                    end
                end
            end

            ST_SUB: begin
                // one A entry compared per cycle against the current B entry
                if (!b_ok) begin
                    n_sub   = 1'b1;
                    n_state = ST_TERM;
                end else if (!a_ok) begin
                    n_sub   = 1'b0;
                    n_state = ST_TERM;
                end else if (a_val == b_val) begin
                    n_j = r_j + 1'b1;
                    n_i = '0;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            ST_TERM: begin
                if (out_free) begin
                    emit                 = 1'b1;
                    emit_item.is_element = 1'b0;
                    emit_item.subset     = r_sub;
                    emit_item.out_count  = r_k;
                    emit_item.last       = 1'b1;
                    n_count_a            = '0;
                    n_count_b            = '0;
                    n_dropped            = 1'b0;
                    n_state              = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        if (emit && emit_item.is_element) begin
            n_k = r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_list_a[r_count_a[IW-1:0]] <= i_cmd.value;
        end
        if (we_b) begin
            r_list_b[r_count_b[IW-1:0]] <= i_cmd.value;
        end
        if (out_free) begin
            r_out_item <= emit_item;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        r_sub <= n_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count_a <= n_count_a;
            r_count_b <= n_count_b;
            r_dropped <= n_dropped;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_a <= DEPTH_C)
        else $error("list A fill count beyond depth");

    a_count_b_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_b <= DEPTH_C)
        else $error("list B fill count beyond depth");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TERM && out_free) |=>
            (r_count_a == '0 && r_count_b == '0 && !r_dropped && r_state == ST_IDLE))
        else $error("terminator did not clear the lists");

    a_sub_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUB) |-> (r_i <= r_count_a && r_j <= r_count_b))
        else $error("subset scan index out of range");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == ST_IDLE && i_cmd_valid))
        else $error("command taken outside idle");

endmodule

FILE: rtl/core/sorted_set_operations_top.sv
// sorted_set_operations_top: top level of the sorted set operations block.
// Depends on ssop_pkg, ssop_front, ssop_cmdq and ssop_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): each item appends a
//   signed value to list A or list B, or starts a run. Unknown request codes
//   are taken and dropped. Appends to a full list are dropped and flagged in
//   the overflow bit of the next run's items.
//   Output channel (o_out_valid / i_out_stall / o_out_item): a run yields its
//   element items followed by one terminator (last = 1) carrying the count
//   and, in subset mode, the answer. The run then empties both lists.
//   Config: i_cfg_we writes i_cfg_data into op_mode (0 merge, 1 intersect,
//   2 B-subset-of-A); write it only while the block is idle.
// Timing:
//   The front classifies items into a two-entry command queue, so input is
//   taken while the back is busy or the output is stalled, until it fills.
//   The back retires one append per cycle while it is idle. A run leaves idle
//   for the merge, intersection or subset scan (one compare per cycle for
//   subset), then emits the terminator. A run item passes through the queue
//   and the back's state register before its first result is registered.
//   A stalled receiver holds the output register and the back waits in merge,
//   intersection or terminator, though a subset scan runs on; appends queue
//   behind a waiting run.
// Reset: synchronous, active low; lists empty, overflow clear, op_mode 0.
module sorted_set_operations_top #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ssop_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ssop_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_we,
    input  logic [ssop_pkg::MODE_W-1:0] i_cfg_data
);

    logic [ssop_pkg::MODE_W-1:0] r_op_mode;

    logic           q_full;
    logic           q_push;
    ssop_pkg::t_cmd q_push_cmd;
    logic           q_valid;
    ssop_pkg::t_cmd q_cmd;
    logic           q_pop;

    // mode register; only sampled by the back when a run leaves the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= ssop_pkg::MODE_MERGE;
        end else if (i_cfg_we) begin
            r_op_mode <= i_cfg_data;
        end
    end

    ssop_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd)
    );

    ssop_cmdq u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (q_pop)
    );

    ssop_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_op_mode),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
